/* hw/rtl/scwm_pkg.sv */
// Package for the serial command word matcher: request codes, characters, keyword compare.
package scwm_pkg;

    localparam int WORD_BUFFER_SIZE_DEF = 16;
    localparam int KEY_LEN              = 5;

    typedef enum logic [2:0] {
        REQ_START   = 3'd0,
        REQ_STOP    = 3'd1,
        REQ_RESET   = 3'd2,
        REQ_DIST    = 3'd3,
        REQ_HOLD    = 3'd4,
        REQ_UNKNOWN = 3'd5
    } t_request;

    // First character of a word sits in the top byte, so string literals compare directly.
    typedef logic [KEY_LEN-1:0][7:0] t_word;

    typedef struct packed {
        logic     hit;
        t_request req;
    } t_match;

    localparam logic [7:0] CH_ONE    = "1";
    localparam logic [7:0] CH_ZERO   = "0";
    localparam logic [7:0] CH_H_LO   = "h";
    localparam logic [7:0] CH_H_UP   = "H";
    localparam logic [7:0] CH_R_LO   = "r";
    localparam logic [7:0] CH_R_UP   = "R";
    localparam logic [7:0] CH_D_LO   = "d";
    localparam logic [7:0] CH_D_UP   = "D";
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_A_LO   = "a";
    localparam logic [7:0] CH_Z_LO   = "z";
    localparam logic [7:0] CASE_BIT  = 8'h20;

    localparam logic [39:0] KW_START = "START";
    localparam logic [31:0] KW_STOP  = "STOP";
    localparam logic [39:0] KW_RESET = "RESET";
    localparam logic [31:0] KW_DIST  = "DIST";

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CH_A_LO && b <= CH_Z_LO) begin
            r = b & ~CASE_BIT;
        end
        return r;
    endfunction

    // is4 / is5: the word holds exactly four / five characters.
    function automatic t_match match_word(input t_word w, input logic is4, input logic is5);
        t_match m;
        m.hit = 1'b1;
        m.req = REQ_UNKNOWN;
        if (is5 && w == KW_START) begin
            m.req = REQ_START;
        end else if (is4 && w[KEY_LEN-1:1] == KW_STOP) begin
            m.req = REQ_STOP;
        end else if (is5 && w == KW_RESET) begin
            m.req = REQ_RESET;
        end else if (is4 && w[KEY_LEN-1:1] == KW_DIST) begin
            m.req = REQ_DIST;
        end else begin
            m.hit = 1'b0;
        end
        return m;
    endfunction

endpackage

/* hw/rtl/scwm_rx_if.sv */
// Byte channel into the matcher: valid, ready and one received byte.
interface scwm_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* hw/rtl/scwm_req_if.sv */
// Request channel out of the matcher: valid, ready and one request code.
interface scwm_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] request;

    modport source (output valid, output request, input ready);
    modport sink   (input valid, input request, output ready);
endinterface

/* hw/rtl/serial_command_word_matcher_core.sv */
// Serial command word matcher: byte decode, word buffer and keyword compare in one pass.
// Flow: a transferred byte is held in the input register and decoded once the result
//   slot is free; its request, if any, stays registered until the sink takes it.
// Throughput: one byte per cycle unless o_req stalls; the compare is one parallel pass.
// Reset (i_rst_n low, synchronous): empties the input and output registers and sets the
//   word length to zero; stored characters keep stale data and are never read unwritten.
module serial_command_word_matcher_core
    import scwm_pkg::*;
#(
    parameter int WORD_BUFFER_SIZE = WORD_BUFFER_SIZE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    scwm_rx_if.sink       i_rx,
    scwm_req_if.source    o_req
);

    localparam int LEN_W = $clog2(WORD_BUFFER_SIZE);
    localparam logic [LEN_W-1:0] CAPACITY = LEN_W'(WORD_BUFFER_SIZE - 1);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Word state: only the first KEY_LEN characters can ever decide a match,
    // so only those are kept; the length still counts up to full capacity.
    logic [LEN_W-1:0] r_len,  n_len;
    t_word            r_word, n_word;

    // Output register
    logic     r_out_valid, n_out_valid;
    t_request r_out_req,   n_out_req;

    logic     advance;
    logic     process;
    logic [7:0] up_byte;
    t_word    cand_word;
    t_match   m_line, m_append;

    // Advance the decode stage whenever the result slot is free or being drained.
    assign advance    = !r_out_valid || o_req.ready;
    assign process    = r_in_valid && advance;
    assign i_rx.ready = !r_in_valid || advance;

    assign o_req.valid   = r_out_valid;
    assign o_req.request = r_out_req;

    assign up_byte = to_upper(r_in_byte);

    // Word as it would stand after appending the current byte.
    always_comb begin
        for (int i = 0; i < KEY_LEN; i++) begin
            cand_word[KEY_LEN-1-i] = (r_len == LEN_W'(i)) ? up_byte : r_word[KEY_LEN-1-i];
        end
    end

    assign m_line   = match_word(r_word, r_len == LEN_W'(4), r_len == LEN_W'(5));
    assign m_append = match_word(cand_word, r_len == LEN_W'(3), r_len == LEN_W'(4));

    always_comb begin
        n_len       = r_len;
        n_word      = r_word;
        n_out_req   = r_out_req;
        n_out_valid = r_out_valid && !o_req.ready;
        if (process) begin
            n_out_valid = 1'b0;
            case (r_in_byte)
                CH_ONE: begin
                    n_len = '0; n_out_valid = 1'b1; n_out_req = REQ_START;
                end
                CH_ZERO: begin
                    n_len = '0; n_out_valid = 1'b1; n_out_req = REQ_STOP;
                end
                CH_H_LO, CH_H_UP: begin
                    n_len = '0; n_out_valid = 1'b1; n_out_req = REQ_HOLD;
                end
                CH_R_LO, CH_R_UP: begin
                    n_len = '0; n_out_valid = 1'b1; n_out_req = REQ_RESET;
                end
                CH_D_LO, CH_D_UP: begin
                    n_len = '0; n_out_valid = 1'b1; n_out_req = REQ_DIST;
                end
                CH_CR, CH_LF: begin
                    // Line end on an empty word: drop silently.
                    if (r_len != '0) begin
                        n_len       = '0;
                        n_out_valid = 1'b1;
                        n_out_req   = m_line.hit ? m_line.req : REQ_UNKNOWN;
                    end
                end
                default: begin
                    if (r_len < CAPACITY) begin
                        n_word = cand_word;
                        if (m_append.hit) begin
                            n_len       = '0;
                            n_out_valid = 1'b1;
                            n_out_req   = m_append.req;
                        end else begin
                            n_len = r_len + LEN_W'(1);
                        end
                    end else begin
                        // Full buffer: clear it and drop the byte.
                        n_len = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_len       <= '0;
        end else begin
            if (i_rx.valid && i_rx.ready) begin
                r_in_valid <= 1'b1;
            end else if (process) begin
                r_in_valid <= 1'b0;
            end
            r_out_valid <= n_out_valid;
            r_len       <= n_len;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
        r_word    <= n_word;
        r_out_req <= n_out_req;
    end

endmodule
